[hdl/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants, types and round helpers for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // controller phases
    typedef enum logic [3:0] {
        ST_IDLE,     // waiting for a transfer
        ST_PAD,      // writing 0x80 / zero / length bytes
        ST_ROUND,    // 80-round compression, one round per cycle
        ST_ADD,      // fold working vars into chaining words
        ST_OUT       // digest waiting on the master side
    } state_t;

    // start/done strobes between controller and round unit
    typedef struct packed {
        logic start;
    } core_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
    } core_sts_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

endpackage

[hdl/sha1_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream with padding and a five-word digest.
// ----------------------------------------------------------------------------
// Each transfer carries one byte (or none) and a last flag. A byte is stored
// in a 64-byte block memory; the 64th byte of a block starts an 80-round
// compression at one round per cycle, during which no transfer is taken. On
// last, the pad byte, zeros and the big-endian bit length are written one
// byte per cycle into the block memory, followed by one or two compressions;
// the digest then waits in an output register and the chaining words return
// to their initial values.
module sha1_byte_stream_hasher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // byte_valid
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // digest_word0..digest_word4 from bit 0 up
);

    // block memory, four bytes wide, written one byte lane at a time
    logic [31:0] blk_mem [16];
    logic [31:0] rd_data_reg;

    sha1_pkg::state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        final_reg, final_next;   // pending compress is the last one
    logic        m_valid_reg, m_valid_next;
    logic [159:0] m_data_reg;
    logic        pad_pend_reg, pad_pend_next;
    logic        mark_reg, mark_next;  // 0x80 still to be written

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte;
    logic        s_acc, m_acc;
    logic        clear;
    logic [3:0]  word_addr;

    sha1_pkg::core_ctl_t ctl;
    sha1_pkg::core_sts_t sts;

    sha1_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .clear     (clear),
        .word_addr (word_addr),
        .word_data (rd_data_reg),
        .sts       (sts)
    );

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // pad byte for the current fill position
    logic [7:0] pad_byte;
    always_comb begin
        if (fill_reg >= 6'd56) begin
            pad_byte = bits_reg[8*(7 - (fill_reg[2:0])) +: 8];
        end else begin
            pad_byte = 8'd0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        final_next = final_reg;
        case (state_reg)
            sha1_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tuser && fill_reg == 6'd63) begin
                        // full block first; padding follows after it if last
                        state_next = sha1_pkg::ST_ROUND;
                        final_next = 1'b0;
                    end else if (s_tlast) begin
                        // pad marker goes at the byte after the data
                        state_next = sha1_pkg::ST_PAD;
                        final_next = 1'b0;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                // marker was written on entry; fill zeros/length
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    state_next = sha1_pkg::ST_ROUND;
                    final_next = final_reg | (fill_reg == 6'd63 && final_reg);
                end
            end
            sha1_pkg::ST_ROUND: begin
                if (sts.done) begin
                    state_next = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                state_next = sha1_pkg::ST_IDLE;
                if (final_reg) begin
                    state_next = sha1_pkg::ST_OUT;
                end else if (pad_pend_reg) begin
                    state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_OUT: begin
                if (!m_valid_reg || m_acc) begin
                    state_next = sha1_pkg::ST_IDLE;
                    fill_next  = 6'd0;
                    bits_next  = 64'd0;
                end
            end
            default: state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    // padding bookkeeping: length fits in this block or needs another
    always_comb begin
        pad_pend_next = pad_pend_reg;
        mark_next     = mark_reg;
        if (state_reg == sha1_pkg::ST_IDLE && s_acc && s_tlast) begin
            pad_pend_next = 1'b1;
            mark_next     = 1'b1;
        end else if (state_reg == sha1_pkg::ST_PAD) begin
            mark_next = 1'b0;
        end else if (state_reg == sha1_pkg::ST_ADD && final_reg) begin
            pad_pend_next = 1'b0;
        end
    end

    // write port: data bytes, pad marker, zeros, length
    logic len_ok;  // this block will carry the length
    logic pad_final_reg;
    assign len_ok = pad_final_reg;
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_byte = s_tdata;
        if (state_reg == sha1_pkg::ST_IDLE) begin
            wr_en = s_acc && s_tuser;
        end else if (state_reg == sha1_pkg::ST_PAD) begin
            wr_en = 1'b1;
            if (mark_reg) begin
                wr_byte = sha1_pkg::PAD_BYTE;
            end else if (len_ok) begin
                wr_byte = pad_byte;
            end else begin
                wr_byte = 8'd0;
            end
        end
    end

    // whether current padding block carries the length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_final_reg <= 1'b0;
        end else if (state_reg == sha1_pkg::ST_PAD && mark_reg) begin
            // marker at fill_reg; length fits if marker lands at 55 or below
            pad_final_reg <= (fill_reg <= 6'd55);
        end else if (state_reg == sha1_pkg::ST_ADD && !final_reg && pad_pend_reg) begin
            pad_final_reg <= 1'b1;
        end
    end

    // final flag set once a length-bearing block reaches the rounds
    logic final_set;
    assign final_set = (state_reg == sha1_pkg::ST_PAD) && (fill_reg == 6'd63)
                       && (mark_reg ? (fill_reg <= 6'd55) : pad_final_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1_pkg::ST_IDLE;
            fill_reg     <= 6'd0;
            bits_reg     <= 64'd0;
            final_reg    <= 1'b0;
            pad_pend_reg <= 1'b0;
            mark_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            final_reg    <= final_set ? 1'b1 : final_next;
            pad_pend_reg <= pad_pend_next;
            mark_reg     <= mark_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // byte-lane write and registered word read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            blk_mem[wr_addr[5:2]][8*(3 - wr_addr[1:0]) +: 8] <= wr_byte;
        end
        rd_data_reg <= blk_mem[word_addr];
    end

    assign ctl.start = (state_reg != sha1_pkg::ST_ROUND) && (state_next == sha1_pkg::ST_ROUND);
    assign clear = (state_reg == sha1_pkg::ST_OUT) && (state_next == sha1_pkg::ST_IDLE);

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_acc) begin
            m_valid_next = 1'b0;
        end
        if (clear) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            m_data_reg <= {sts.h4, sts.h3, sts.h2, sts.h1, sts.h0};
        end
    end

    assign s_tready = (state_reg == sha1_pkg::ST_IDLE) && !sts.busy;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/sha1_core.sv]
// ----------------------------------------------------------------------------
// sha1_core
// Round unit: reads the block from the buffer memory one word per round,
// keeps the 16-word schedule in a shift line, and updates the chaining words.
// ----------------------------------------------------------------------------
module sha1_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha1_pkg::core_ctl_t ctl,
    input  logic                clear,     // restore initial chaining words
    output logic [3:0]          word_addr, // block word read address
    input  logic [31:0]         word_data, // registered read data
    output sha1_pkg::core_sts_t sts
);

    logic [6:0]  rnd_reg, rnd_next;
    logic        run_reg, run_next;
    logic        fetch_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic        done_reg;

    // rounds 16..79 need w[r-3], w[r-8], w[r-14], w[r-16]; keep a shift line
    logic [31:0] sh_reg [16];

    logic [31:0] w_cur, f_val, k_val, t_val;

    // word fetch runs one round ahead so read data lines up with the round
    assign word_addr = rnd_next[3:0];

    // schedule word of the current round
    always_comb begin
        if (rnd_reg < 7'd16) begin
            w_cur = word_data;
        end else begin
            w_cur = sha1_pkg::rotl1(sh_reg[2] ^ sh_reg[7] ^ sh_reg[13] ^ sh_reg[15]);
        end
    end

    // round function and constant
    always_comb begin
        if (rnd_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K0;
        end else if (rnd_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K1;
        end else if (rnd_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + k_val;
    end

    // round counter
    always_comb begin
        run_next = run_reg;
        rnd_next = rnd_reg;
        if (ctl.start) begin
            run_next = 1'b0;
            rnd_next = 7'd0;
        end else if (fetch_reg) begin
            run_next = 1'b1;
        end else if (run_reg) begin
            if (rnd_reg == 7'd79) begin
                run_next = 1'b0;
            end else begin
                rnd_next = rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            fetch_reg <= 1'b0;
            done_reg  <= 1'b0;
            rnd_reg   <= 7'd0;
        end else begin
            run_reg   <= run_next;
            fetch_reg <= ctl.start;
            rnd_reg   <= rnd_next;
            done_reg  <= run_reg && (rnd_reg == 7'd79);
        end
    end

    // working variables, schedule line and chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            h0_reg <= sha1_pkg::IV0;
            h1_reg <= sha1_pkg::IV1;
            h2_reg <= sha1_pkg::IV2;
            h3_reg <= sha1_pkg::IV3;
            h4_reg <= sha1_pkg::IV4;
        end else if (done_reg) begin
            h0_reg <= h0_reg + a_reg;
            h1_reg <= h1_reg + b_reg;
            h2_reg <= h2_reg + c_reg;
            h3_reg <= h3_reg + d_reg;
            h4_reg <= h4_reg + e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_reg) begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
            e_reg <= h4_reg;
        end else if (run_reg) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            sh_reg[0] <= w_cur;
            for (int i = 1; i < 16; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign sts.busy = run_reg | fetch_reg | done_reg;
    assign sts.done = done_reg;
    assign sts.h0   = h0_reg;
    assign sts.h1   = h1_reg;
    assign sts.h2   = h2_reg;
    assign sts.h3   = h3_reg;
    assign sts.h4   = h4_reg;

endmodule

[bench/sha1_byte_stream_hasher_tb.sv]
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_tb
// Self-checking bench for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
// Messages of random length and content go in one byte per transfer. Some
// end with a byte and last together, others with a bare last. A few idle
// transfers are mixed in. A local SHA-1 predictor follows every accepted
// input transfer and queues the digest for each finished message. The
// monitor checks every output transfer against the oldest queued digest.
// Both sides idle at random in phases. One long receiver stall backs up
// the block, and a few messages wait until all digests have drained.
module sha1_byte_stream_hasher_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 500;
    localparam int TAIL_CYCLES    = 400;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       drain;      // wait for all digests before offering
    } byte_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;     // [7:0] data_byte
    logic         s_tuser = 1'b0;   // byte_valid
    logic         s_tlast = 1'b0;   // last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;          // digest_word0..digest_word4 from bit 0 up

    byte_item_t   pending_bytes[$];
    logic [159:0] digest_q[$];
    logic         started = 1'b0;
    logic         s_fired = 1'b0;
    int           bytes_sent = 0;
    int           digests_seen = 0;
    int           mismatches = 0;
    int           hold_cnt = 0;
    bit           hold_done = 0;
    int           idle_cnt = 0;

    // predictor state
    logic [31:0]  chain[5];
    logic [7:0]   blk[64];
    int           fill;
    logic [63:0]  msg_bits;

    sha1_byte_stream_hasher dut (.*);

    always #10 aclk = ~aclk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic chain_restart();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
        fill     = 0;
        msg_bits = '0;
    endtask

    task automatic compress_blk();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 80; r++)
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + w[r] + k;
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    // one accepted transfer into the predictor
    task automatic hash_transfer(input logic [7:0] db, input logic bv, input logic lst);
        if (bv) begin
            blk[fill] = db;
            fill = (fill + 1) % 64;
            msg_bits += 64'd8;
            if (fill == 0) compress_blk();
        end
        if (lst) begin
            blk[fill] = 8'h80;
            fill++;
            if (fill > 56) begin
                while (fill < 64) blk[fill++] = 8'h00;
                compress_blk();
                fill = 0;
            end
            while (fill < 56) blk[fill++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[8*(7-i) +: 8];
            compress_blk();
            digest_q.push_back({chain[4], chain[3], chain[2], chain[1], chain[0]});
            chain_restart();
        end
    endtask

    task automatic add_byte(input logic [7:0] db, input logic bv, input logic lst,
                            input logic drn);
        byte_item_t it;
        it.data_byte  = db;
        it.byte_valid = bv;
        it.last       = lst;
        it.drain      = drn;
        pending_bytes.push_back(it);
    endtask

    // random message: mostly short, some around the padding boundary, a few long
    task automatic add_message(input logic drn);
        int len, sel;
        bit bare_last;
        sel = $urandom_range(99);
        if (sel < 65)      len = $urandom_range(0, 20);
        else if (sel < 90) len = $urandom_range(50, 70);
        else               len = $urandom_range(100, 130);
        bare_last = (len == 0) || ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) add_byte(8'($urandom), 1'b0, 1'b0, 1'b0);
            add_byte(8'($urandom), 1'b1, !bare_last && (i == len - 1), drn && (i == 0));
        end
        if (bare_last) add_byte(8'($urandom), 1'b0, 1'b1, drn && (len == 0));
    endtask

    // stimulus and end of run
    initial begin
        chain_restart();
        // directed: empty message, extremes, idle transfer, byte with last
        add_byte(8'h00, 1'b0, 1'b1, 1'b0);
        add_byte(8'h00, 1'b1, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hA5, 1'b1, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        add_byte(8'h80, 1'b1, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b1, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1, 1'b1);
        while (pending_bytes.size() < 800)
            add_message($urandom_range(99) < 6);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        started <= 1'b1;
        wait (pending_bytes.size() == 0 && !s_tvalid && digest_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && digest_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // driver: offer the next byte at the falling edge
    always @(negedge aclk) begin
        int idle_pct;
        idle_pct = (bytes_sent < 270) ? 17 : (bytes_sent < 540) ? 48 : 0;
        if (!s_tvalid || s_fired) begin
            if (started && pending_bytes.size() != 0 &&
                !(pending_bytes[0].drain && digest_q.size() != 0) &&
                $urandom_range(99) >= idle_pct) begin
                s_tdata  <= pending_bytes[0].data_byte;
                s_tuser  <= pending_bytes[0].byte_valid;
                s_tlast  <= pending_bytes[0].last;
                s_tvalid <= 1'b1;
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold once traffic is flowing
    always @(negedge aclk) begin
        int idle_pct;
        idle_pct = (bytes_sent < 270) ? 48 : (bytes_sent < 540) ? 17 : 0;
        if (!hold_done && digests_seen >= 4) begin
            hold_done = 1;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // input side: predict on every accepted transfer
    always @(posedge aclk) begin
        s_fired <= s_tvalid && s_tready && aresetn;
        if (aresetn && s_tvalid && s_tready)
            hash_transfer(s_tdata, s_tuser, s_tlast);
    end

    // output side: compare each digest with the oldest prediction
    always @(posedge aclk) begin
        logic [159:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected digest %h", m_tdata);
            end else begin
                want = digest_q.pop_front();
                for (int i = 0; i < 5; i++) begin
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: digest %0d word%0d expected %h got %h",
                                     digests_seen, i, want[32*i +: 32],
                                     m_tdata[32*i +: 32]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

endmodule
